// ===== sv/lpr_pkg.sv =====
package lpr_pkg;

    localparam int GEN_W      = 31;
    localparam int MULT_W     = 15;
    localparam int PROD_W     = GEN_W + MULT_W;
    localparam int VAL_W      = 32;
    localparam int SPAN_W     = VAL_W + 1;
    localparam int DIV_STEPS  = GEN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [MULT_W-1:0] LCG_MULT    = 15'd16807;
    localparam logic [GEN_W-1:0]  LCG_MODULUS = 31'h7fffffff;
    localparam logic [GEN_W-1:0]  SEED_RESET  = 31'd2;

    // register index taken from the word address
    localparam logic REG_SEED = 1'b0;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== sv/lpr_req_if.sv =====
interface lpr_req_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic signed [lpr_pkg::VAL_W-1:0]  range_low;
    logic signed [lpr_pkg::VAL_W-1:0]  range_high;

    modport source (output valid, action, range_low, range_high, input ready);
    modport sink   (input valid, action, range_low, range_high, output ready);
endinterface

// ===== sv/lpr_rsp_if.sv =====
interface lpr_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [lpr_pkg::VAL_W-1:0]  value;
    logic                              bad_range;

    modport source (output valid, value, bad_range, input ready);
    modport sink   (input valid, value, bad_range, output ready);
endinterface

// ===== sv/lehmer_prng_with_range_core.sv =====
// Minimal standard Lehmer generator, x <= 16807 * x mod (2^31 - 1), with an
// optional ranged draw. A raw draw returns x - 1; a ranged draw returns
// ((x - 1) mod (range_high - range_low + 1)) + range_low, and flags
// bad_range with value 0 when range_low >= range_high. One word is worked on
// at a time and i_req.ready is low meanwhile. A raw draw or a rejected range
// passes S_MUL and S_RED, then waits in S_FIN for a free output register; a
// valid ranged draw also passes S_DIV, where the divider forms the modulo one
// bit per cycle over the 31 generator bits. A finished word waits in the
// output register, and a new request is taken while it waits. Writing the
// seed register (byte address 0) loads the generator at once; a seed of 0
// becomes 1 and a seed of 2^31-1 becomes 2^31-2. Reset loads seed 2.
module lehmer_prng_with_range_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lpr_req_if.sink                           i_req,
    lpr_rsp_if.source                         o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lpr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lpr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import lpr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_RED  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state                  r_state;
    logic [GEN_W-1:0]        r_seed;
    logic [GEN_W-1:0]        r_gen;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_action;
    logic signed [VAL_W-1:0] r_lo;
    logic signed [VAL_W-1:0] r_hi;
    logic [SPAN_W-1:0]       r_span;
    logic                    r_bad;
    logic [VAL_W-1:0]        r_res_value;
    logic                    r_res_bad;
    logic                    r_out_valid;
    logic [VAL_W-1:0]        r_out_value;
    logic                    r_out_bad;

    logic                    in_acc;
    logic                    cfg_wr;
    logic [GEN_W-1:0]        seed_lim;
    logic [GEN_W:0]          red_sum;
    logic [GEN_W:0]          red_sub;
    logic [GEN_W-1:0]        n_gen;
    logic [GEN_W-1:0]        raw;
    logic                    out_load;
    logic                    div_start;
    t_div_stat               div_stat;
    logic [VAL_W-1:0]        div_rem;

    assign in_acc   = i_req.valid && i_req.ready;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_SEED);
    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    // keep the seed inside 1 .. 2^31-2
    always_comb begin
        seed_lim = pwdata[GEN_W-1:0];
        if (seed_lim == '0) begin
            seed_lim = GEN_W'(1);
        end else if (seed_lim == LCG_MODULUS) begin
            seed_lim = LCG_MODULUS - 1'b1;
        end
    end

    // mod 2^31-1 by folding the high bits onto the low bits
    always_comb begin
        red_sum = {1'b0, r_prod[GEN_W-1:0]} + (GEN_W+1)'(r_prod[PROD_W-1:GEN_W]);
        red_sub = red_sum - {1'b0, LCG_MODULUS};
        if (red_sum >= {1'b0, LCG_MODULUS}) begin
            n_gen = red_sub[GEN_W-1:0];
        end else begin
            n_gen = red_sum[GEN_W-1:0];
        end
        raw = n_gen - 1'b1;
    end

    assign div_start = (r_state == S_RED) && r_action && !r_bad;

    lpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (raw),
        .i_divisor  (r_span),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= SEED_RESET;
            r_gen       <= SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_seed <= seed_lim;
                r_gen  <= seed_lim;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_gen <= n_gen;
                    if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_req.action;
            r_lo     <= i_req.range_low;
            r_hi     <= i_req.range_high;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_gen * LCG_MULT;
            r_span <= {r_hi[VAL_W-1], r_hi} - {r_lo[VAL_W-1], r_lo} + SPAN_W'(1);
            r_bad  <= r_action && (r_lo >= r_hi);
        end
        if (r_state == S_RED) begin
            if (!r_action) begin
                r_res_value <= VAL_W'(raw);
                r_res_bad   <= 1'b0;
            end else begin
                r_res_value <= '0;
                r_res_bad   <= r_bad;
            end
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_res_value <= div_rem + r_lo;
        end
        if (out_load) begin
            r_out_value <= r_res_value;
            r_out_bad   <= r_res_bad;
        end
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.value     = r_out_value;
    assign o_rsp.bad_range = r_out_bad;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEED) ? APB_DATA_W'(r_seed) : '0;

endmodule

// ===== sv/lpr_div.sv =====
module lpr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lpr_pkg::GEN_W-1:0]     i_dividend,
    input  logic [lpr_pkg::SPAN_W-1:0]    i_divisor,
    output lpr_pkg::t_div_stat            o_stat,
    output logic [lpr_pkg::VAL_W-1:0]     o_rem
);
    import lpr_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SPAN_W-1:0]    r_rem;
    logic [GEN_W-1:0]     r_dvd;
    logic [SPAN_W-1:0]    r_dvs;

    logic [SPAN_W:0]      trial;
    logic [SPAN_W:0]      diff;
    logic [SPAN_W-1:0]    n_rem;

    // restoring step: one dividend bit per cycle
    always_comb begin
        trial = {r_rem, r_dvd[GEN_W-1]};
        diff  = trial - {1'b0, r_dvs};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = diff[SPAN_W-1:0];
        end else begin
            n_rem = trial[SPAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + 1'b1;
                r_done <= (r_cnt == LAST_STEP);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[GEN_W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    // remainder stays below the span, which is at most 2^32
    assign o_rem       = r_rem[VAL_W-1:0];

endmodule

// ===== sv/lpr_checker.sv =====
module lpr_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [lpr_pkg::VAL_W-1:0]   i_out_value,
    input  logic                        i_out_bad_range
);
    import lpr_pkg::*;

    // a waiting word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_bad_range))
        else $error("output word changed while stalled");

    // after taking a word, the generator is not ready again during S_MUL and S_RED
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("request taken while previous word still in work");

    // a rejected range always reads as zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad_range |-> i_out_value == '0)
        else $error("bad_range word with nonzero value");

    // a new result never appears in the cycle right after a request is taken
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared too early");

endmodule

bind lehmer_prng_with_range_core lpr_checker u_lpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_out_value     (o_rsp.value),
    .i_out_bad_range (o_rsp.bad_range)
);
